FILE: hdl/qmi_pkg.sv
`timescale 1ns / 1ps

package qmi_pkg;

    localparam int DEPTH   = 1024;
    localparam int HALF    = (DEPTH + 1) / 2;
    localparam int PTR_W   = (HALF > 1) ? $clog2(HALF) : 1;
    localparam int CNT_W   = $clog2(HALF + 1);
    localparam int TOT_W   = CNT_W + 1;
    localparam int DATA_W  = 32;
    localparam int OCC_W   = 11;
    localparam int ACT_W   = 2;
    localparam int STAT_W  = 2;

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [TOT_W-1:0]  tot_t;
    typedef logic [DATA_W-1:0] data_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_INSERT = 2'd2
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE   = 2'd0,
        ST_POPPED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic  we;
        ptr_t  waddr;
        data_t wdata;
        logic  re;
        ptr_t  raddr;
    } ram_req_t;

    typedef struct packed {
        status_t          status;
        data_t            popped_value;
        logic [OCC_W-1:0] occupancy;
    } result_t;

    function automatic ptr_t ptr_inc(ptr_t p);
        ptr_t r;
        if (p == ptr_t'(HALF - 1))
            r = '0;
        else
            r = p + ptr_t'(1);
        return r;
    endfunction

    function automatic ptr_t ptr_dec(ptr_t p);
        ptr_t r;
        if (p == '0)
            r = ptr_t'(HALF - 1);
        else
            r = p - ptr_t'(1);
        return r;
    endfunction

endpackage

FILE: hdl/qmi_ram.sv
`timescale 1ns / 1ps

module qmi_ram
    import qmi_pkg::*;
(
    input  logic     clk,
    input  ram_req_t req,
    output data_t    rdata
);

    data_t mem [HALF];
    data_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
            mem[req.waddr] <= req.wdata;
        if (req.re)
            rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/qmi_ctrl.sv
`timescale 1ns / 1ps

module qmi_ctrl
    import qmi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  action_t  action,
    input  data_t    item_value,
    output logic     idle,
    output ram_req_t front_req,
    output ram_req_t back_req,
    input  data_t    front_rdata,
    input  data_t    back_rdata,
    output logic     res_valid,
    output result_t  res
);

    state_t  state_reg, state_next;
    action_t act_reg, act_next;
    data_t   val_reg, val_next;
    ptr_t    frp_reg, frp_next;
    ptr_t    fwp_reg, fwp_next;
    ptr_t    brp_reg, brp_next;
    ptr_t    bwp_reg, bwp_next;
    cnt_t    fc_reg, fc_next;
    cnt_t    bc_reg, bc_next;

    tot_t total;
    assign total = tot_t'(fc_reg) + tot_t'(bc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            frp_reg   <= '0;
            fwp_reg   <= '0;
            brp_reg   <= '0;
            bwp_reg   <= '0;
            fc_reg    <= '0;
            bc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            frp_reg   <= frp_next;
            fwp_reg   <= fwp_next;
            brp_reg   <= brp_next;
            bwp_reg   <= bwp_next;
            fc_reg    <= fc_next;
            bc_reg    <= bc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg <= act_next;
        val_reg <= val_next;
    end

    always_comb
    begin
        logic  move;
        data_t mv;
        tot_t  want;
        tot_t  tot_after;

        move       = 1'b0;
        mv         = back_rdata;
        want       = '0;
        tot_after  = '0;
        state_next = state_reg;
        act_next   = act_reg;
        val_next   = val_reg;
        frp_next   = frp_reg;
        fwp_next   = fwp_reg;
        brp_next   = brp_reg;
        bwp_next   = bwp_reg;
        fc_next    = fc_reg;
        bc_next    = bc_reg;
        idle       = 1'b0;
        res_valid  = 1'b0;
        res        = '{status: ST_DONE, popped_value: '0, occupancy: '0};
        front_req  = '{we: 1'b0, waddr: fwp_reg, wdata: val_reg, re: 1'b0, raddr: frp_reg};
        back_req   = '{we: 1'b0, waddr: bwp_reg, wdata: val_reg, re: 1'b0, raddr: brp_reg};

        case (state_reg)
            S_IDLE:
            begin
                idle         = 1'b1;
                front_req.re = accept;
                back_req.re  = accept;
                if (accept)
                begin
                    act_next   = action;
                    val_next   = item_value;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_valid  = 1'b1;
                state_next = S_IDLE;
                case (act_reg)
                    ACT_PUSH:
                    begin
                        if (total >= tot_t'(DEPTH))
                            res.status = ST_FULL;
                        else
                        begin
                            back_req.we = 1'b1;
                            bwp_next    = ptr_inc(bwp_reg);
                            want        = (total + tot_t'(2)) >> 1;
                            move        = tot_t'(fc_reg) < want;
                            // back half empty: its head is the value being pushed
                            mv          = (bc_reg == '0) ? val_reg : back_rdata;
                            if (move)
                            begin
                                brp_next = ptr_inc(brp_reg);
                                fc_next  = fc_reg + cnt_t'(1);
                            end
                            else
                                bc_next = bc_reg + cnt_t'(1);
                        end
                    end
                    ACT_POP:
                    begin
                        if (fc_reg == '0)
                            res.status = ST_EMPTY;
                        else
                        begin
                            res.status       = ST_POPPED;
                            res.popped_value = front_rdata;
                            frp_next         = ptr_inc(frp_reg);
                            want             = total >> 1;
                            move = (tot_t'(fc_reg) - tot_t'(1) < want) && (bc_reg != '0);
                            if (move)
                            begin
                                brp_next = ptr_inc(brp_reg);
                                bc_next  = bc_reg - cnt_t'(1);
                            end
                            else
                                fc_next = fc_reg - cnt_t'(1);
                        end
                    end
                    ACT_INSERT:
                    begin
                        if (total >= tot_t'(DEPTH))
                            res.status = ST_FULL;
                        else if (!total[0])
                        begin
                            front_req.we = 1'b1;
                            fwp_next     = ptr_inc(fwp_reg);
                            fc_next      = fc_reg + cnt_t'(1);
                        end
                        else
                        begin
                            back_req.we    = 1'b1;
                            back_req.waddr = ptr_dec(brp_reg);
                            brp_next       = ptr_dec(brp_reg);
                            bc_next        = bc_reg + cnt_t'(1);
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (move)
                begin
                    front_req.we    = 1'b1;
                    front_req.wdata = mv;
                    fwp_next        = ptr_inc(fwp_reg);
                end
                tot_after     = tot_t'(fc_next) + tot_t'(bc_next);
                res.occupancy = OCC_W'(tot_after);
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_balanced: assert property (@(posedge clk) disable iff (!rst_n)
        tot_t'(fc_reg) == ((total + tot_t'(1)) >> 1))
        else $error("half queues out of balance");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        total <= tot_t'(DEPTH))
        else $error("occupancy above depth");

    a_exec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept && idle |=> state_reg == S_EXEC)
        else $error("accepted transaction not executed");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |=> state_reg == S_IDLE && !res_valid)
        else $error("result not single");
`endif

endmodule

FILE: hdl/queue_with_middle_insert.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tuser: action; tdata: item_value
// m_*      out  m_tvalid/m_tready  tuser: status; tdata: popped_value, occupancy
//
// Each transaction reads the heads of both half-queue RAMs on accept and
// updates and writes back in the next cycle, as the RAM read data is registered.
// The result sits in an output register; s_tready is low in the update cycle
// and while a result waits, and rises in the cycle m_tready takes it.
// Reset empties the queue at once; RAM contents are not cleared.

module queue_with_middle_insert
    import qmi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] item_value
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] popped_value, [42:32] occupancy
    output logic [1:0]  m_tuser    // [1:0] status
);

    ram_req_t front_req, back_req;
    data_t    front_rdata, back_rdata;
    logic     idle;
    logic     accept;
    logic     res_valid;
    result_t  res;

    logic     m_valid_reg, m_valid_next;
    result_t  m_res_reg;

    assign s_tready = idle && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    qmi_ram u_front_ram (
        .clk   (clk),
        .req   (front_req),
        .rdata (front_rdata)
    );

    qmi_ram u_back_ram (
        .clk   (clk),
        .req   (back_req),
        .rdata (back_rdata)
    );

    qmi_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .action      (action_t'(s_tuser)),
        .item_value  (s_tdata),
        .idle        (idle),
        .front_req   (front_req),
        .back_req    (back_req),
        .front_rdata (front_rdata),
        .back_rdata  (back_rdata),
        .res_valid   (res_valid),
        .res         (res)
    );

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (res_valid)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
            m_res_reg <= res;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {5'b0, m_res_reg.occupancy, m_res_reg.popped_value};

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !m_valid_reg)
        else $error("result register overwritten");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> res_valid)
        else $error("transaction produced no result");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");
`endif

endmodule
